FILE: hw/rtl/uvb_pkg.sv
// ----------------------------------------------------------------------------
// uvb_pkg
// shared widths and defaults for the uv basis affine remap datapath
// ----------------------------------------------------------------------------
package uvb_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W   = 32;   // input and output term width
    localparam int DIFF_W    = 33;   // point difference
    localparam int PROD_W    = 66;   // product of two differences
    localparam int TERM_W    = 67;   // determinant and adjugate terms
    localparam int LO_W      = 34;   // low slice of a term for split multiply
    localparam int HI_W      = TERM_W - LO_W;
    localparam int PLO_W     = COORD_W + LO_W + 1;
    localparam int PHI_W     = COORD_W + HI_W;
    localparam int TR_W      = 100;  // translation numerator
    localparam int DMAG_W    = 66;   // magnitude of the determinant
    localparam int Q_W       = 32;   // quotient bits
    localparam int NLANE     = 6;    // one divider lane per output term
    localparam int NPROD     = 10;
    localparam int NIN       = 12;

    localparam int S_TDATA_W = NIN * COORD_W;
    localparam int M_TDATA_W = NLANE * COORD_W;

endpackage

FILE: hw/rtl/uv_basis_affine_remap.sv
// ----------------------------------------------------------------------------
// uv_basis_affine_remap
// throughput: one basis pair per cycle while m_tready is high; the 32 restoring
// divider stages and the split 32x67 multiplies are fully pipelined, so each
// stage takes a word every clock unless stalled, and bubbles collapse under back pressure
// reset: rst_n clears all stage valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module uv_basis_affine_remap
    import uvb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // ref_p0_u, ref_p0_v, ref_p1_u, ref_p1_v, ref_p2_u, ref_p2_v,
    // tgt_p0_u, tgt_p0_v, tgt_p1_u, tgt_p1_v, tgt_p2_u, tgt_p2_v
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // u_per_s, u_per_t, v_per_s, v_per_t, u_offset, v_offset
    output logic [M_TDATA_W-1:0] m_tdata,
    // singular
    output logic                 m_tuser
);

    localparam int MW0   = (TERM_W + FRAC_BITS > TR_W) ? TERM_W + FRAC_BITS : TR_W;
    localparam int NUM_W = MW0 + 1;
    localparam int NSTG  = 8 + Q_W + 2;
    localparam int SD0   = 7;          // divider setup stage
    localparam int SRND  = 8 + Q_W;    // rounding stage
    localparam int SOUT  = SRND + 1;

    // stage valid and advance
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // input unpack
    logic signed [COORD_W-1:0] in_f [NIN];

    always_comb
    begin
        for (int k = 0; k < NIN; k++)
        begin
            in_f[k] = $signed(s_tdata[k*COORD_W +: COORD_W]);
        end
    end

    // stage 1: edge vectors
    logic signed [DIFF_W-1:0]  xu_reg, xv_reg, yu_reg, yv_reg;
    logic signed [DIFF_W-1:0]  au_reg, av_reg, bu_reg, bv_reg;
    logic signed [COORD_W-1:0] r0u_reg [3];
    logic signed [COORD_W-1:0] r0v_reg [3];
    logic signed [COORD_W-1:0] t0u_reg [3];
    logic signed [COORD_W-1:0] t0v_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xu_reg     <= DIFF_W'(in_f[4])  - DIFF_W'(in_f[0]);
            xv_reg     <= DIFF_W'(in_f[5])  - DIFF_W'(in_f[1]);
            yu_reg     <= DIFF_W'(in_f[2])  - DIFF_W'(in_f[0]);
            yv_reg     <= DIFF_W'(in_f[3])  - DIFF_W'(in_f[1]);
            au_reg     <= DIFF_W'(in_f[10]) - DIFF_W'(in_f[6]);
            av_reg     <= DIFF_W'(in_f[11]) - DIFF_W'(in_f[7]);
            bu_reg     <= DIFF_W'(in_f[8])  - DIFF_W'(in_f[6]);
            bv_reg     <= DIFF_W'(in_f[9])  - DIFF_W'(in_f[7]);
            r0u_reg[0] <= in_f[0];
            r0v_reg[0] <= in_f[1];
            t0u_reg[0] <= in_f[6];
            t0v_reg[0] <= in_f[7];
        end
    end

    // stage 2: products of differences
    logic signed [PROD_W-1:0] p_reg [NPROD];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg[0]   <= xu_reg * yv_reg;
            p_reg[1]   <= yu_reg * xv_reg;
            p_reg[2]   <= au_reg * yv_reg;
            p_reg[3]   <= bu_reg * xv_reg;
            p_reg[4]   <= bu_reg * xu_reg;
            p_reg[5]   <= au_reg * yu_reg;
            p_reg[6]   <= av_reg * yv_reg;
            p_reg[7]   <= bv_reg * xv_reg;
            p_reg[8]   <= bv_reg * xu_reg;
            p_reg[9]   <= av_reg * yu_reg;
            r0u_reg[1] <= r0u_reg[0];
            r0v_reg[1] <= r0v_reg[0];
            t0u_reg[1] <= t0u_reg[0];
            t0v_reg[1] <= t0v_reg[0];
        end
    end

    // stage 3: determinant and adjugate products
    logic signed [TERM_W-1:0] det_reg [4];
    logic signed [TERM_W-1:0] n00_reg [4];
    logic signed [TERM_W-1:0] n01_reg [4];
    logic signed [TERM_W-1:0] n10_reg [4];
    logic signed [TERM_W-1:0] n11_reg [4];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            det_reg[0] <= TERM_W'(p_reg[0]) - TERM_W'(p_reg[1]);
            n00_reg[0] <= TERM_W'(p_reg[2]) - TERM_W'(p_reg[3]);
            n01_reg[0] <= TERM_W'(p_reg[4]) - TERM_W'(p_reg[5]);
            n10_reg[0] <= TERM_W'(p_reg[6]) - TERM_W'(p_reg[7]);
            n11_reg[0] <= TERM_W'(p_reg[8]) - TERM_W'(p_reg[9]);
            r0u_reg[2] <= r0u_reg[1];
            r0v_reg[2] <= r0v_reg[1];
            t0u_reg[2] <= t0u_reg[1];
            t0v_reg[2] <= t0v_reg[1];
        end
    end

    // stage 4: translation products, each split into two partial products
    logic signed [COORD_W-1:0] ma [6];
    logic signed [TERM_W-1:0]  mb [6];
    logic signed [PLO_W-1:0]   plo_reg [6];
    logic signed [PHI_W-1:0]   phi_reg [6];

    always_comb
    begin
        ma[0] = t0u_reg[2];  mb[0] = det_reg[0];
        ma[1] = r0u_reg[2];  mb[1] = n00_reg[0];
        ma[2] = r0v_reg[2];  mb[2] = n01_reg[0];
        ma[3] = t0v_reg[2];  mb[3] = det_reg[0];
        ma[4] = r0u_reg[2];  mb[4] = n10_reg[0];
        ma[5] = r0v_reg[2];  mb[5] = n11_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int k = 0; k < 6; k++)
            begin
                plo_reg[k] <= ma[k] * $signed({1'b0, mb[k][LO_W-1:0]});
                phi_reg[k] <= ma[k] * $signed(mb[k][TERM_W-1:LO_W]);
            end
            det_reg[1] <= det_reg[0];
            n00_reg[1] <= n00_reg[0];
            n01_reg[1] <= n01_reg[0];
            n10_reg[1] <= n10_reg[0];
            n11_reg[1] <= n11_reg[0];
        end
    end

    // stage 5: recombine partial products
    logic signed [TR_W-1:0] pf_reg [6];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int k = 0; k < 6; k++)
            begin
                pf_reg[k] <= (TR_W'(phi_reg[k]) <<< LO_W) + TR_W'(plo_reg[k]);
            end
            det_reg[2] <= det_reg[1];
            n00_reg[2] <= n00_reg[1];
            n01_reg[2] <= n01_reg[1];
            n10_reg[2] <= n10_reg[1];
            n11_reg[2] <= n11_reg[1];
        end
    end

    // stage 6: translation numerators
    logic signed [TR_W-1:0] tu_reg, tv_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            tu_reg     <= pf_reg[0] - pf_reg[1] - pf_reg[2];
            tv_reg     <= pf_reg[3] - pf_reg[4] - pf_reg[5];
            det_reg[3] <= det_reg[2];
            n00_reg[3] <= n00_reg[2];
            n01_reg[3] <= n01_reg[2];
            n10_reg[3] <= n10_reg[2];
            n11_reg[3] <= n11_reg[2];
        end
    end

    // stage 7: numerator and divisor magnitudes, result signs
    logic signed [NUM_W-1:0] num [NLANE];
    logic [NLANE-1:0]        negate;
    logic                    det_neg;

    always_comb
    begin
        num[0] = NUM_W'(n00_reg[3]) <<< FRAC_BITS;
        num[1] = NUM_W'(n01_reg[3]) <<< FRAC_BITS;
        num[2] = NUM_W'(n10_reg[3]) <<< FRAC_BITS;
        num[3] = NUM_W'(n11_reg[3]) <<< FRAC_BITS;
        num[4] = NUM_W'(tu_reg);
        num[5] = NUM_W'(tv_reg);
        negate = NLANE'(6'b011100);
        det_neg = det_reg[3][TERM_W-1];
    end

    logic [NUM_W-1:0]  rem_reg  [Q_W+1][NLANE];
    logic [Q_W-1:0]    q_reg    [Q_W+1][NLANE];
    logic [NLANE-1:0]  neg_reg  [Q_W+1];
    logic [NLANE-1:0]  sat_reg  [Q_W+1];
    logic [DMAG_W-1:0] dmag_reg [Q_W+1];
    logic              sing_reg [Q_W+1];
    logic [NUM_W-1:0]  mag7_reg [NLANE];
    logic [NLANE-1:0]  neg7_reg;
    logic [DMAG_W-1:0] dmag7_reg;
    logic              sing7_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                mag7_reg[l] <= num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
                neg7_reg[l] <= num[l][NUM_W-1] ^ negate[l] ^ det_neg;
            end
            dmag7_reg <= det_neg ? DMAG_W'(-det_reg[3]) : DMAG_W'(det_reg[3]);
            sing7_reg <= (det_reg[3] == '0);
        end
    end

    // stage 8: quotient overflow check against divisor shifted by Q_W
    always_ff @(posedge clk)
    begin
        if (en[SD0])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                rem_reg[0][l]    <= mag7_reg[l];
                q_reg[0][l]      <= '0;
                sat_reg[0][l]    <= mag7_reg[l] >= (NUM_W'(dmag7_reg) << Q_W);
            end
            neg_reg[0]  <= neg7_reg;
            dmag_reg[0] <= dmag7_reg;
            sing_reg[0] <= sing7_reg;
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < Q_W; j++)
    begin : g_div
        localparam int BIT = Q_W - 1 - j;
        logic [NUM_W-1:0] dsh;
        logic [NUM_W-1:0] diff [NLANE];
        logic [NLANE-1:0] ge;
        logic [Q_W-1:0]   qn [NLANE];

        always_comb
        begin
            dsh = NUM_W'(dmag_reg[j]) << BIT;
            for (int l = 0; l < NLANE; l++)
            begin
                diff[l]    = rem_reg[j][l] - dsh;
                ge[l]      = rem_reg[j][l] >= dsh;
                qn[l]      = q_reg[j][l];
                qn[l][BIT] = ge[l];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[SD0+1+j])
            begin
                for (int l = 0; l < NLANE; l++)
                begin
                    rem_reg[j+1][l]     <= ge[l] ? diff[l] : rem_reg[j][l];
                    q_reg[j+1][l]       <= qn[l];
                    sat_reg[j+1][l]     <= sat_reg[j][l];
                end
                neg_reg[j+1]  <= neg_reg[j];
                dmag_reg[j+1] <= dmag_reg[j];
                sing_reg[j+1] <= sing_reg[j];
            end
        end
    end

    // round to nearest, ties away from zero
    logic [Q_W:0]     qr_reg [NLANE];
    logic [NLANE-1:0] negr_reg;
    logic [NLANE-1:0] satr_reg;
    logic             singr_reg;

    always_ff @(posedge clk)
    begin
        if (en[SRND])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                qr_reg[l] <= {1'b0, q_reg[Q_W][l]}
                           + (Q_W+1)'({rem_reg[Q_W][l][DMAG_W-1:0], 1'b0}
                                      >= {1'b0, dmag_reg[Q_W]});
            end
            negr_reg  <= neg_reg[Q_W];
            satr_reg  <= sat_reg[Q_W];
            singr_reg <= sing_reg[Q_W];
        end
    end

    // saturate, apply sign, clear on singular basis
    localparam logic [Q_W:0] POS_MAX = (Q_W+1)'((64'd1 << (Q_W - 1)) - 64'd1);
    localparam logic [Q_W:0] NEG_MAX = (Q_W+1)'(64'd1 << (Q_W - 1));

    logic [COORD_W-1:0] res_reg [NLANE];
    logic               sing_out_reg;

    always_ff @(posedge clk)
    begin
        if (en[SOUT])
        begin
            for (int l = 0; l < NLANE; l++)
            begin
                if (singr_reg)
                begin
                    res_reg[l] <= '0;
                end
                else if (!negr_reg[l])
                begin
                    res_reg[l] <= (satr_reg[l] || qr_reg[l] > POS_MAX)
                                ? POS_MAX[COORD_W-1:0] : qr_reg[l][COORD_W-1:0];
                end
                else
                begin
                    res_reg[l] <= (satr_reg[l] || qr_reg[l] > NEG_MAX)
                                ? NEG_MAX[COORD_W-1:0] : COORD_W'(-qr_reg[l]);
                end
            end
            sing_out_reg <= singr_reg;
        end
    end

    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            m_tdata[l*COORD_W +: COORD_W] = res_reg[l];
        end
    end

    assign m_tuser = sing_out_reg;

endmodule

FILE: dv/uv_basis_affine_remap_chk.sv
// ----------------------------------------------------------------------------
// uv_basis_affine_remap_chk
// watches both stream channels, computes the expected remap terms for every
// accepted basis pair and compares them in order with the output words
// ----------------------------------------------------------------------------
module uv_basis_affine_remap_chk
    import uvb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic                 singular;
        logic [M_TDATA_W-1:0] terms;
    } remap_t;

    remap_t remap_q[$];

    assign pending = remap_q.size();

    // round num/den to nearest, ties away from zero, saturate to 32 bits
    function automatic logic [31:0] div_round_sat(logic signed [159:0] num,
                                                  logic signed [159:0] den);
        logic               neg;
        logic [159:0]       n;
        logic [159:0]       d;
        logic [159:0]       q;
        logic [159:0]       r;
        neg = num[159] ^ den[159];
        n = num[159] ? -num : num;
        d = den[159] ? -den : den;
        q = n / d;
        r = n % d;
        if (2 * r >= d)
            q = q + 1;
        if (!neg)
            return (q > 160'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        if (q > 160'h8000_0000)
            return 32'h8000_0000;
        return -q[31:0];
    endfunction

    function automatic remap_t remap_predict(logic [S_TDATA_W-1:0] w);
        logic signed [159:0] c[NIN];
        logic signed [159:0] xu, xv, yu, yv, au, av, bu, bv, det;
        logic signed [159:0] n00, n01, n10, n11, tu, tv, sc;
        remap_t res;
        for (int i = 0; i < NIN; i++)
            c[i] = $signed(w[i*COORD_W +: COORD_W]);
        xu = c[4] - c[0];  xv = c[5] - c[1];
        yu = c[2] - c[0];  yv = c[3] - c[1];
        au = c[10] - c[6]; av = c[11] - c[7];
        bu = c[8] - c[6];  bv = c[9] - c[7];
        det = xu * yv - yu * xv;
        res = '0;
        if (det == 0)
        begin
            res.singular = 1'b1;
            return res;
        end
        n00 = au * yv - bu * xv;
        n01 = bu * xu - au * yu;
        n10 = av * yv - bv * xv;
        n11 = bv * xu - av * yu;
        tu = c[6] * det - n00 * c[0] - n01 * c[1];
        tv = c[7] * det - n10 * c[0] - n11 * c[1];
        sc = 160'sd1 <<< FRAC_BITS;
        res.terms[0*32 +: 32] = div_round_sat(n00 * sc, det);
        res.terms[1*32 +: 32] = div_round_sat(n01 * sc, det);
        res.terms[2*32 +: 32] = div_round_sat(-(n10 * sc), det);
        res.terms[3*32 +: 32] = div_round_sat(-(n11 * sc), det);
        res.terms[4*32 +: 32] = div_round_sat(-tu, det);
        res.terms[5*32 +: 32] = div_round_sat(tv, det);
        return res;
    endfunction

    always @(posedge clk)
    begin
        remap_t exp_w;
        if (!rst_n)
        begin
            errors = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                remap_q.push_back(remap_predict(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (remap_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output word %h", m_tdata);
                end
                else
                begin
                    exp_w = remap_q.pop_front();
                    if (exp_w.singular !== m_tuser || exp_w.terms !== m_tdata)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp sing %b %h, got sing %b %h",
                                     exp_w.singular, exp_w.terms, m_tuser, m_tdata);
                    end
                end
            end
        end
    end

endmodule

FILE: dv/uv_basis_affine_remap_tb.sv
// ----------------------------------------------------------------------------
// uv_basis_affine_remap_tb
// drives directed and random basis pairs with random idling on both sides
// and reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module uv_basis_affine_remap_tb;
    import uvb_pkg::*;

    localparam int LATENCY  = 42;
    localparam int N_RANDOM = 1700;
    localparam int LIMIT    = 1000000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    int                   errors;
    int                   pending;
    int                   cycles;
    int                   send_idle;
    int                   recv_idle;
    int                   hold_off;
    bit                   hold_go;
    bit                   hold_done;

    uv_basis_affine_remap u_top (.*);

    uv_basis_affine_remap_chk u_chk (.*);

    always
    begin
        clk = 1'b1; #1;
        clk = 1'b0; #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("uv_basis_affine_remap regression: fail");
            $finish;
        end
    end

    // receiver with random stalls and a single long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_off  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_off  <= 400;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(511) - 256;
            3: return {16'($urandom_range(15) - 8), 16'h0};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic [S_TDATA_W-1:0] w);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [S_TDATA_W-1:0] pack_pair(logic [31:0] c[NIN]);
        logic [S_TDATA_W-1:0] w;
        for (int i = 0; i < NIN; i++)
            w[i*COORD_W +: COORD_W] = c[i];
        return w;
    endfunction

    initial
    begin
        logic [31:0] c[NIN];
        logic [S_TDATA_W-1:0] w;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        rst_n     = 1'b0;
        hold_go   = 1'b0;
        send_idle = 12;
        recv_idle = 73;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit basis against itself, then scaled and shifted targets
        c = '{0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000,
              0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000};
        send_word(pack_pair(c));
        c[6] = 32'h0003_8000; c[7] = 32'hFFFE_0000; c[11] = 32'h7FFF_FFFF;
        send_word(pack_pair(c));
        // singular reference: collinear and coincident points
        for (int i = 0; i < NIN; i++)
            c[i] = 32'h1234_5678;
        send_word(pack_pair(c));
        c[2] = 32'h1234_5679; c[4] = 32'h1234_567A;
        c[3] = 32'h1234_5679; c[5] = 32'h1234_567A;
        send_word(pack_pair(c));
        // extremes everywhere, tiny determinant for saturation
        for (int k = 0; k < 8; k++)
        begin
            for (int i = 0; i < NIN; i++)
                c[i] = (($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF);
            c[0] = 0; c[1] = 0; c[2] = 1; c[3] = 32'(k[0]); c[4] = 32'(k[1]); c[5] = 1;
            send_word(pack_pair(c));
        end
        c = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_word(pack_pair(c));
        c[1] = 32'h7FFF_FFFF; c[3] = 32'h8000_0000; c[0] = 32'h7FFF_FFFF;
        send_word(pack_pair(c));

        // long receiver hold-off while the sender keeps offering
        hold_go <= 1'b1;
        for (int k = 0; k < 80; k++)
        begin
            for (int i = 0; i < NIN; i++)
                c[i] = rand_coord();
            send_word(pack_pair(c));
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 12 : (ph == 1) ? 73 : 0;
            recv_idle = (ph == 0) ? 73 : (ph == 1) ? 12 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++)
            begin
                for (int i = 0; i < NIN; i++)
                    c[i] = rand_coord();
                // sometimes force a singular reference
                if ($urandom_range(15) == 0)
                begin
                    c[4] = c[0]; c[5] = c[1];
                end
                w = pack_pair(c);
                if ($urandom_range(3) == 0)
                    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                send_word(w);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0)
            $display("uv_basis_affine_remap regression: pass");
        else
            $display("uv_basis_affine_remap regression: fail");
        $finish;
    end

endmodule
